// ===== hw/rtl/lfu_cache_table_assert.svh =====
// Assertion macros used by the checker file lfu_chk.sv.
`ifndef LFU_CACHE_TABLE_ASSERT_SVH
`define LFU_CACHE_TABLE_ASSERT_SVH

// Check a property at every rising clock edge outside reset.
`define LFU_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("lfu_cache_table: assertion failed");

// Check that a condition in one cycle implies another in the next cycle.
`define LFU_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lfu_cache_table: assertion failed");

`endif

// ===== hw/rtl/lfu_pkg.sv =====
package lfu_pkg;

  // Table geometry
  localparam int Entries = 16;
  localparam int IdxW    = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int RankW   = IdxW;
  localparam int OccW    = $clog2(Entries + 1);
  localparam int CapW    = 5;
  localparam int CmpW    = (OccW > CapW) ? OccW : CapW;
  localparam int UseBits = 16;
  localparam int DataW   = 32;

  // Configuration port
  localparam int AddrW  = 3;
  localparam int PDataW = 32;
  localparam logic RegCapacity = 1'b0;
  localparam logic [CapW-1:0] CapReset = CapW'(16);

  localparam logic [UseBits-1:0] UseMax    = '1;
  localparam logic [UseBits-1:0] UseOne    = UseBits'(1);
  localparam logic [DataW-1:0]   MissValue = '1;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e              cmd;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic signed [31:0] value_out;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SELECT,
    ST_UPDATE,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_USE,
    ACT_REPLACE,
    ACT_INSERT
  } act_e;

  // Outcome of one pass over the table
  typedef struct packed {
    logic            hit;
    logic [IdxW-1:0] hit_idx;
    logic            vic_any;
    logic [IdxW-1:0] vic_idx;
    logic            free_any;
    logic [IdxW-1:0] free_idx;
  } scan_res_t;

endpackage

// ===== hw/rtl/lfu_cache_table.sv =====
// Key-value table with least-frequently-used replacement, least recently
// used entry losing among equal use counts.
// Input channel in_valid_i/in_ready_o carries one item: get (cmd 0) looks
// up key, put (cmd 1) stores key and value. Each item gives one result on
// out_valid_o/out_ready_i: found, and value_out (stored value on a get hit,
// all ones on a get miss, zero on a put).
// Each item makes one pass over the table with a single key and use-count
// comparator at one entry per cycle, then a select, an update and a result
// state. in_ready_o is high only while the sequencer is idle.
// The result sits in an output register; while the receiver stalls, the
// next item is still taken, and its result waits until the register frees.
// Reset empties the table and sets capacity to 16. Capacity is written over
// the APB port at byte address 0 (bits 4:0); the user must write it only
// while the block is idle, and the block itself does not enforce this.
module lfu_cache_table
  import lfu_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_item_t          in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [PDataW-1:0] pwdata,
  output logic [PDataW-1:0] prdata,
  output logic              pready
);

  // Table storage
  logic [Entries-1:0]  valid_q, valid_d;
  logic [DataW-1:0]    key_q   [Entries];
  logic [DataW-1:0]    data_q  [Entries];
  logic [UseBits-1:0]  uses_q  [Entries];
  logic [RankW-1:0]    rank_q  [Entries];
  logic [RankW-1:0]    rank_d  [Entries];
  logic [OccW-1:0]     occ_q, occ_d;
  logic [CapW-1:0]     cap_q;

  // Sequencer and item registers
  state_e              state_q, state_d;
  in_item_t            item_q;
  logic [IdxW-1:0]     idx_q;
  act_e                act_q, act_d;
  out_item_t           res_q, res_d, out_q;
  logic                out_valid_q;

  // Control strobes
  logic                accept, scan_step, sel_en, upd_en, out_load, scan_last;
  scan_res_t           scan_res;

  // Select and update datapath
  logic [CmpW-1:0]     cap_ext, cap_eff, occ_ext;
  logic [IdxW-1:0]     slot_sel;
  logic [RankW-1:0]    rank_s;
  logic [UseBits-1:0]  uses_s;
  logic [DataW-1:0]    data_s;
  logic                wr_entry;

  assign scan_last = (idx_q == IdxW'(Entries - 1));
  assign accept    = in_valid_i && in_ready_o;

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (psel && penable && pwrite && pready && (paddr[AddrW-1] == RegCapacity)) begin
      cap_q <= pwdata[CapW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[AddrW-1] == RegCapacity) ? PDataW'(cap_q) : '0;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_SCAN;
      ST_SCAN:   if (scan_last) state_d = ST_SELECT;
      ST_SELECT: state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_DONE;
      ST_DONE:   if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    scan_step  = 1'b0;
    sel_en     = 1'b0;
    upd_en     = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE:   in_ready_o = 1'b1;
      ST_SCAN:   scan_step  = 1'b1;
      ST_SELECT: sel_en     = 1'b1;
      ST_UPDATE: upd_en     = 1'b1;
      ST_DONE:   out_load   = !out_valid_q || out_ready_i;
      default:   in_ready_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Walk the table one entry per cycle
  lfu_scan_unit u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept),
    .step_i      (scan_step),
    .idx_i       (idx_q),
    .ent_valid_i (valid_q[idx_q]),
    .ent_key_i   (key_q[idx_q]),
    .ent_uses_i  (uses_q[idx_q]),
    .ent_rank_i  (rank_q[idx_q]),
    .key_i       (item_q.key),
    .res_o       (scan_res)
  );

  // Pick the action and the slot it works on
  assign cap_ext = CmpW'(cap_q);
  assign cap_eff = (cap_ext > CmpW'(Entries)) ? CmpW'(Entries) : cap_ext;
  assign occ_ext = CmpW'(occ_q);

  always_comb begin
    act_d    = ACT_NONE;
    slot_sel = scan_res.hit_idx;
    if (item_q.cmd == CMD_GET) begin
      if (scan_res.hit) begin
        act_d = ACT_USE;
      end
    end else if (cap_eff != '0) begin
      if (scan_res.hit) begin
        act_d = ACT_USE;
      end else if (occ_ext >= cap_eff) begin
        slot_sel = scan_res.vic_idx;
        if (scan_res.vic_any) begin
          act_d = ACT_REPLACE;
        end
      end else begin
        slot_sel = scan_res.free_idx;
        if (scan_res.free_any) begin
          act_d = ACT_INSERT;
        end
      end
    end
  end

  // Item, pointer and action registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_i;
      idx_q  <= '0;
    end else if (scan_step && !scan_last) begin
      idx_q <= idx_q + IdxW'(1);
    end else if (sel_en) begin
      idx_q <= slot_sel;
      act_q <= act_d;
    end
  end

  // Entry under the pointer during the update cycle
  assign rank_s   = rank_q[idx_q];
  assign uses_s   = uses_q[idx_q];
  assign data_s   = data_q[idx_q];
  assign wr_entry = upd_en && ((act_q == ACT_REPLACE) || (act_q == ACT_INSERT));

  // Age recency ranks in parallel and mark the slot most recent
  always_comb begin
    rank_d  = rank_q;
    valid_d = valid_q;
    occ_d   = occ_q;
    if (upd_en) begin
      for (int i = 0; i < Entries; i++) begin
        if (valid_q[i] && (IdxW'(i) != idx_q)) begin
          case (act_q)
            ACT_USE:     if (rank_q[i] < rank_s) rank_d[i] = rank_q[i] + RankW'(1);
            ACT_REPLACE: if (rank_q[i] <= rank_s) rank_d[i] = rank_q[i] + RankW'(1);
            ACT_INSERT:  rank_d[i] = rank_q[i] + RankW'(1);
            default:     rank_d[i] = rank_q[i];
          endcase
        end
      end
      if (act_q != ACT_NONE) begin
        rank_d[idx_q] = '0;
      end
      if (act_q == ACT_INSERT) begin
        valid_d[idx_q] = 1'b1;
        occ_d          = occ_q + OccW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
    end else begin
      valid_q <= valid_d;
      occ_q   <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rank_q <= rank_d;
  end

  // Write key, value and use count at the pointer
  always_ff @(posedge clk_i) begin
    if (wr_entry) begin
      key_q[idx_q]  <= item_q.key;
      data_q[idx_q] <= item_q.value;
      uses_q[idx_q] <= UseOne;
    end else if (upd_en && (act_q == ACT_USE)) begin
      if (uses_s != UseMax) begin
        uses_q[idx_q] <= uses_s + UseBits'(1);
      end
      if (item_q.cmd == CMD_PUT) begin
        data_q[idx_q] <= item_q.value;
      end
    end
  end

  // Form the result
  always_comb begin
    res_d.found = scan_res.hit;
    if (item_q.cmd == CMD_PUT) begin
      res_d.value_out = '0;
    end else if (scan_res.hit) begin
      res_d.value_out = data_s;
    end else begin
      res_d.value_out = MissValue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_en) begin
      res_q <= res_d;
    end
    if (out_load) begin
      out_q <= res_q;
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== hw/rtl/lfu_scan_unit.sv =====
module lfu_scan_unit
  import lfu_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               step_i,
  input  logic [IdxW-1:0]    idx_i,
  input  logic               ent_valid_i,
  input  logic [DataW-1:0]   ent_key_i,
  input  logic [UseBits-1:0] ent_uses_i,
  input  logic [RankW-1:0]   ent_rank_i,
  input  logic [DataW-1:0]   key_i,
  output scan_res_t          res_o
);

  logic               hit_q, vic_any_q, free_any_q;
  logic [IdxW-1:0]    hit_idx_q, vic_idx_q, free_idx_q;
  logic [UseBits-1:0] vic_uses_q;
  logic [RankW-1:0]   vic_rank_q;
  logic               match, better;

  // Shared key compare and victim compare for the entry under the pointer
  assign match  = ent_valid_i && (ent_key_i == key_i);
  assign better = !vic_any_q || (ent_uses_i < vic_uses_q) ||
                  ((ent_uses_i == vic_uses_q) && (ent_rank_i > vic_rank_q));

  // Track hit, victim and first free slot flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q      <= 1'b0;
      vic_any_q  <= 1'b0;
      free_any_q <= 1'b0;
    end else if (start_i) begin
      hit_q      <= 1'b0;
      vic_any_q  <= 1'b0;
      free_any_q <= 1'b0;
    end else if (step_i) begin
      if (match) begin
        hit_q <= 1'b1;
      end
      if (ent_valid_i && better) begin
        vic_any_q <= 1'b1;
      end
      if (!ent_valid_i) begin
        free_any_q <= 1'b1;
      end
    end
  end

  // Capture the matching indexes and the best victim so far
  always_ff @(posedge clk_i) begin
    if (step_i && !start_i) begin
      if (match && !hit_q) begin
        hit_idx_q <= idx_i;
      end
      if (ent_valid_i && better) begin
        vic_idx_q  <= idx_i;
        vic_uses_q <= ent_uses_i;
        vic_rank_q <= ent_rank_i;
      end
      if (!ent_valid_i && !free_any_q) begin
        free_idx_q <= idx_i;
      end
    end
  end

  assign res_o.hit      = hit_q;
  assign res_o.hit_idx  = hit_idx_q;
  assign res_o.vic_any  = vic_any_q;
  assign res_o.vic_idx  = vic_idx_q;
  assign res_o.free_any = free_any_q;
  assign res_o.free_idx = free_idx_q;

endmodule

// ===== hw/rtl/lfu_chk.sv =====
`include "lfu_cache_table_assert.svh"

module lfu_chk
  import lfu_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input out_item_t         out_o,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [AddrW-1:0]  paddr,
  input logic [PDataW-1:0] pwdata,
  input logic [PDataW-1:0] prdata,
  input logic              pready
);

  // Config port never waits
  `LFU_ASSERT(a_pready_high, pready)

  // The sequencer drops ready right after taking an item
  `LFU_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)

  // No result shows up the cycle after an item is taken
  `LFU_ASSERT_NEXT(a_no_early_result, in_valid_i && in_ready_o, !$rose(out_valid_o))

  // A stalled result holds
  `LFU_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_o))

  // Capacity reads back what was written
  `LFU_ASSERT_NEXT(a_cap_readback, psel && penable && pwrite && !paddr[AddrW-1], paddr[AddrW-1] || (prdata[CapW-1:0] == $past(pwdata[CapW-1:0])))

endmodule

bind lfu_cache_table lfu_chk u_lfu_chk (.*);

// ===== tb/lfu_cache_table_checker.sv =====
`timescale 1ns / 1ps

// Watches both item channels and the register port of lfu_cache_table,
// predicts each reply from its own copy of the table and compares.
module lfu_cache_table_checker
  import lfu_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  in_item_t          in_item_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  out_item_t         out_item_i,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [AddrW-1:0]  paddr_i,
  input  logic [PDataW-1:0] pwdata_i,
  input  logic              pready_i,
  output int                pending_o,
  output int                errors_o
);

  localparam logic [AddrW-1:0] CapAddr = AddrW'(4 * RegCapacity);

  // Shadow table
  logic              slot_valid [Entries];
  logic [31:0]       slot_key   [Entries];
  logic [31:0]       slot_data  [Entries];
  logic [UseBits-1:0] slot_uses [Entries];
  int                slot_rank  [Entries];
  int                fill_count;
  logic [CapW-1:0]   cap_reg;

  out_item_t         awaited_replies [$];
  out_item_t         want;
  int                err_cnt;

  // Count one use of slot s and make it the most recent one
  function automatic void promote_slot(input int s);
    int i;
    if (slot_uses[s] != UseMax) slot_uses[s] = slot_uses[s] + 1'b1;
    for (i = 0; i < Entries; i++)
      if (slot_valid[i] && i != s && slot_rank[i] < slot_rank[s]) slot_rank[i]++;
    slot_rank[s] = 0;
  endfunction

  // Apply one get or put to the shadow table and return its reply
  function automatic out_item_t lfu_access(input in_item_t it);
    out_item_t r;
    int        i;
    int        hit;
    int        s;
    int        limit;
    hit   = -1;
    s     = -1;
    limit = (cap_reg > Entries) ? Entries : int'(cap_reg);
    for (i = 0; i < Entries; i++)
      if (hit < 0 && slot_valid[i] && slot_key[i] == it.key) hit = i;

    r.found     = (hit >= 0);
    r.value_out = '0;

    if (it.cmd == CMD_GET) begin
      if (hit >= 0) begin
        promote_slot(hit);
        r.value_out = slot_data[hit];
      end else begin
        r.value_out = MissValue;
      end
      return r;
    end

    // Puts do nothing with zero capacity
    if (limit == 0) return r;
    if (hit >= 0) begin
      slot_data[hit] = it.value;
      promote_slot(hit);
      return r;
    end

    if (fill_count >= limit) begin
      // Evict lowest use count, oldest among equals
      for (i = 0; i < Entries; i++) begin
        if (slot_valid[i] && (s < 0 || slot_uses[i] < slot_uses[s] ||
            (slot_uses[i] == slot_uses[s] && slot_rank[i] > slot_rank[s])))
          s = i;
      end
      if (s >= 0) begin
        for (i = 0; i < Entries; i++)
          if (slot_valid[i] && i != s && slot_rank[i] > slot_rank[s]) slot_rank[i]--;
        slot_valid[s] = 1'b0;
        fill_count--;
      end
    end else begin
      for (i = 0; i < Entries; i++)
        if (s < 0 && !slot_valid[i]) s = i;
    end
    if (s < 0) return r;

    // Insert the new key as the most recent entry
    for (i = 0; i < Entries; i++)
      if (slot_valid[i]) slot_rank[i]++;
    slot_valid[s] = 1'b1;
    slot_key[s]   = it.key;
    slot_data[s]  = it.value;
    slot_uses[s]  = UseOne;
    slot_rank[s]  = 0;
    fill_count++;
    return r;
  endfunction

  // Compare replies first, then predict the item taken at this edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Entries; i++) begin
        slot_valid[i] = 1'b0;
        slot_key[i]   = '0;
        slot_data[i]  = '0;
        slot_uses[i]  = '0;
        slot_rank[i]  = 0;
      end
      fill_count = 0;
      cap_reg    = CapReset;
      awaited_replies.delete();
      err_cnt    = 0;
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (awaited_replies.size() == 0) begin
          $error("reply with none awaited: found %0d value_out %h",
                 out_item_i.found, out_item_i.value_out);
          err_cnt++;
        end else begin
          want = awaited_replies.pop_front();
          if (out_item_i.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, out_item_i.found);
            err_cnt++;
          end
          if (out_item_i.value_out !== want.value_out) begin
            $error("value_out: expected %h, got %h", want.value_out, out_item_i.value_out);
            err_cnt++;
          end
        end
      end
      if (in_valid_i && in_ready_i) awaited_replies.push_back(lfu_access(in_item_i));
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == CapAddr)
        cap_reg = pwdata_i[CapW-1:0];
      pending_o <= awaited_replies.size();
      errors_o  <= err_cnt;
    end
  end

endmodule

// ===== tb/lfu_cache_table_tb.sv =====
`timescale 1ns / 1ps

module lfu_cache_table_tb;
  import lfu_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 40;
  localparam int Segments    = 12;
  localparam int SegItems    = 108;
  localparam int PressureSeg = 9;
  localparam int PoolMax     = 24;
  localparam logic [AddrW-1:0] CapAddr = AddrW'(4 * RegCapacity);

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  in_item_t          in_item   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_item;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [AddrW-1:0]  paddr     = '0;
  logic [PDataW-1:0] pwdata    = '0;
  logic [PDataW-1:0] prdata;
  logic              pready;

  int pending;
  int errors;
  int cycles        = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req      = 0;
  int hold_ack      = 0;
  int hold_left     = 0;

  logic [31:0] key_pool [PoolMax];
  int          pool_size;

  lfu_cache_table dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_i       (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_o      (out_item),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  lfu_cache_table_checker u_lfu_check (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_i (in_ready),
    .in_item_i  (in_item),
    .out_valid_i(out_valid),
    .out_ready_i(out_ready),
    .out_item_i (out_item),
    .psel_i     (psel),
    .penable_i  (penable),
    .pwrite_i   (pwrite),
    .paddr_i    (paddr),
    .pwdata_i   (pwdata),
    .pready_i   (pready),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("lfu_cache_table_tb: FAIL");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_ack != hold_req) begin
      hold_ack  = hold_req;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one item, maybe after a gap, and hold it until taken
  task automatic send_item(input cmd_e c, input logic [31:0] k, input logic [31:0] v);
    in_item_t nxt;
    nxt.cmd   = c;
    nxt.key   = k;
    nxt.value = v;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(30, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= nxt;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait until every reply is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic apb_write(input logic [AddrW-1:0] a, input logic [PDataW-1:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    int          i;
    int          seg;
    int          n;
    int          pick;
    logic [CapW-1:0] cap;
    cmd_e        c;
    logic [31:0] k;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 28;
    recv_idle_pct = 86;

    // Extremes, hits, misses and overwrite at reset capacity
    send_item(CMD_GET, 32'h0000_0000, 32'h1234_5678);
    send_item(CMD_PUT, 32'h8000_0000, 32'h7fff_ffff);
    send_item(CMD_PUT, 32'h7fff_ffff, 32'h8000_0000);
    send_item(CMD_PUT, 32'h0000_0000, 32'hffff_ffff);
    send_item(CMD_PUT, 32'hffff_ffff, 32'h0000_0000);
    send_item(CMD_GET, 32'h8000_0000, 32'h0000_0000);
    send_item(CMD_GET, 32'hffff_ffff, 32'hffff_ffff);
    send_item(CMD_PUT, 32'h8000_0000, 32'h5555_5555);
    send_item(CMD_GET, 32'h8000_0000, 32'h0000_0000);
    // Fill the table, then force a replacement
    for (i = 1; i <= 12; i++) send_item(CMD_PUT, i, 32'haaaa_0000 | i);
    send_item(CMD_PUT, 32'h0000_1000, 32'h0f0f_0f0f);
    send_item(CMD_GET, 32'h0000_0001, 32'h0000_0000);

    // Zero capacity: puts change nothing, gets still hit
    wait_drained();
    apb_write(CapAddr, '0);
    send_item(CMD_PUT, 32'h0000_2000, 32'h1111_1111);
    send_item(CMD_PUT, 32'h0000_0000, 32'h2222_2222);
    send_item(CMD_GET, 32'h0000_0000, 32'h0000_0000);
    send_item(CMD_GET, 32'h0000_2000, 32'h0000_0000);

    // Capacity below occupancy: one eviction per new key
    wait_drained();
    apb_write(CapAddr, 32'd4);
    send_item(CMD_PUT, 32'h0000_3000, 32'h3333_3333);
    send_item(CMD_GET, 32'h0000_3000, 32'h0000_0000);
    send_item(CMD_GET, 32'h7fff_ffff, 32'h0000_0000);

    // Random segments, each with its own capacity and key pool
    for (seg = 0; seg < Segments; seg++) begin
      case (seg / 4)
        0: begin send_idle_pct = 28; recv_idle_pct = 86; end
        1: begin send_idle_pct = 86; recv_idle_pct = 28; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (seg)
        0:       cap = 5'd16;
        1:       cap = 5'd31;
        2:       cap = 5'd4;
        3:       cap = 5'd1;
        4:       cap = 5'd0;
        5:       cap = 5'd8;
        6:       cap = 5'd17;
        7:       cap = 5'd2;
        8:       cap = 5'd16;
        9:       cap = 5'd12;
        10:      cap = 5'd3;
        default: cap = 5'd16;
      endcase
      pool_size = $urandom_range(PoolMax, 2);
      for (i = 0; i < pool_size; i++) begin
        pick = $urandom_range(9);
        key_pool[i] = (pick == 0) ? 32'h8000_0000 :
                      (pick == 1) ? 32'h7fff_ffff :
                      (pick == 2) ? 32'hffff_ffff : $urandom();
      end

      wait_drained();
      apb_write(CapAddr, PDataW'(cap));
      // Stall the receiver long enough to back up the input
      if (seg == PressureSeg) hold_req = hold_req + 1;

      for (n = 0; n < SegItems; n++) begin
        // Pause the sender until the table has answered everything
        if (seg == PressureSeg && n == 8) wait_drained();
        c = ($urandom_range(99) < 55) ? CMD_PUT : CMD_GET;
        k = ($urandom_range(99) < 85) ? key_pool[$urandom_range(pool_size - 1)] : $urandom();
        send_item(c, k, $urandom());
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("lfu_cache_table_tb: PASS");
    end else begin
      $display("lfu_cache_table_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/lfu_pkg.sv
hw/rtl/lfu_scan_unit.sv
hw/rtl/lfu_cache_table.sv
hw/rtl/lfu_chk.sv
tb/lfu_cache_table_checker.sv
tb/lfu_cache_table_tb.sv
